@@ rtl/core/cphc_pkg.sv @@
// Shared types and constants for the codepoint hash cache.
// Holds the beat structs, the table entry layout, operation codes and FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cphc_pkg;

  localparam int unsigned KEY_W   = 21;
  localparam int unsigned GLYPH_W = 16;
  localparam int unsigned STAMP_W = 32;

  // Multiplicative hash constant (Knuth's golden-ratio multiplier).
  localparam logic [31:0] HASH_MUL = 32'd2654435761;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [KEY_W-1:0]   codepoint;
    logic [GLYPH_W-1:0] glyph_in;
  } in_beat_t;

  typedef struct packed {
    logic               found;
    logic [GLYPH_W-1:0] glyph_out;
    logic               evicted;
  } out_beat_t;

  // One table slot as stored in the entry memory.
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [GLYPH_W-1:0] glyph;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_SCAN,
    ST_EVICT,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/codepoint_hash_cache_lru.sv @@
// Codepoint-to-glyph cache: an open-addressed table with linear probing and
// least-recently-stamped eviction, kept in one single-port-read entry memory.
// After reset the block clears every slot of the memory before it takes its
// first beat; a clear operation repeats that pass. A lookup or insert reads
// each probed slot from memory, then checks it and writes it back; the beat is
// captured before the first probe and the result handed over after the last.
// An insert into a full probe path adds an eviction scan that streams every
// slot through the read port, and then an eviction write. A finished result
// sits in an output register, so the next beat is taken while it waits.
// Depends on cphc_pkg and cphc_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module codepoint_hash_cache_lru #(
  parameter int unsigned SLOTS = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cphc_pkg::in_beat_t   in_beat,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output cphc_pkg::out_beat_t       out_beat
);
  import cphc_pkg::*;

  logic      res_valid;
  logic      res_ready;
  out_beat_t res_beat;
  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_beat_r, out_beat_nxt;

  cphc_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_beat  (res_beat)
  );

  // Output register: loads when empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_beat_nxt  = res_beat;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // A result from the sequencer is never dropped while the register is full.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_beat_r))
    else $error("pending result overwritten");

  // An accepted result beat always leaves the register holding it.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_valid_r && (out_beat_r == $past(res_beat)))
    else $error("result beat not captured");

  // The sequencer only hands over when the register can take it.
  a_handover: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && out_valid_r && !out_ready |=> res_valid)
    else $error("result released without handover");

endmodule

`default_nettype wire

@@ rtl/core/cphc_hash.sv @@
// Home slot computation for the codepoint hash cache.
// Depends on cphc_pkg for the key width and the hash multiplier.
`timescale 1ns / 1ps
`default_nettype none

module cphc_hash #(
  parameter int unsigned SLOTS = 256
) (
  input  wire logic [cphc_pkg::KEY_W-1:0]  codepoint,
  output logic [$clog2(SLOTS)-1:0]          home
);
  import cphc_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam logic [IW-1:0] MASK = IW'(SLOTS - 1);
  localparam logic [IW-1:0] MUL_LO = HASH_MUL[IW-1:0];

  logic [IW-1:0] cp_lo;
  logic [IW-1:0] prod;

  // Only the low bits of the 32-bit product survive the mask, and those
  // depend only on the low bits of both operands.
  assign cp_lo = codepoint[IW-1:0];
  assign prod  = cp_lo * MUL_LO;
  assign home  = prod & MASK;

endmodule

`default_nettype wire

@@ rtl/core/cphc_mem.sv @@
// Entry memory of the codepoint hash cache: one write port, one read port.
// Read data is registered. Depends on cphc_pkg for entry_t.
`timescale 1ns / 1ps
`default_nettype none

module cphc_mem #(
  parameter int unsigned SLOTS = 256
) (
  input  wire logic                        clk,
  input  wire logic                        re,
  input  wire logic [$clog2(SLOTS)-1:0]    raddr,
  output cphc_pkg::entry_t                 rdata,
  input  wire logic                        we,
  input  wire logic [$clog2(SLOTS)-1:0]    waddr,
  input  wire cphc_pkg::entry_t            wdata
);
  import cphc_pkg::*;

  entry_t ram_r [SLOTS];
  entry_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      ram_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= ram_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/core/cphc_ctrl.sv @@
// Sequencer of the codepoint hash cache: probing, eviction scan, clearing sweep.
// Depends on cphc_pkg, cphc_hash and cphc_mem.
`timescale 1ns / 1ps
`default_nettype none

module cphc_ctrl #(
  parameter int unsigned SLOTS = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cphc_pkg::in_beat_t   in_beat,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output cphc_pkg::out_beat_t       res_beat
);
  import cphc_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] MASK     = IW'(SLOTS - 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(SLOTS - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(SLOTS);

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  op_t                 op_r, op_nxt;
  logic [KEY_W-1:0]    cp_r, cp_nxt;
  logic [GLYPH_W-1:0]  gl_r, gl_nxt;
  logic [IW-1:0]       home_r, home_nxt;
  logic [STAMP_W-1:0]  stamp_r, stamp_nxt;
  logic [STAMP_W-1:0]  best_r, best_nxt;
  logic [IW-1:0]       tgt_r, tgt_nxt;
  logic                tgt_vld_r, tgt_vld_nxt;
  logic                scan_vld_r, scan_vld_nxt;
  logic [IW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                sweep_resp_r, sweep_resp_nxt;
  out_beat_t           res_r, res_nxt;

  logic [IW-1:0]       home;
  logic [IW-1:0]       probe_idx;
  logic [STAMP_W-1:0]  stamp_inc;
  logic [STAMP_W-1:0]  stamp_new;
  logic                accept;
  logic                probe_empty;
  logic                probe_hit;
  logic                probe_last;
  logic                scan_issue;
  logic                scan_done;

  logic                mem_re;
  logic [IW-1:0]       mem_raddr;
  entry_t              mem_rdata;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  entry_t              mem_wdata;

  cphc_hash #(.SLOTS(SLOTS)) u_hash (
    .codepoint (in_beat.codepoint),
    .home      (home)
  );

  cphc_mem #(.SLOTS(SLOTS)) u_mem (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  // Shared status terms.
  assign in_ready    = (state_r == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign probe_idx   = (home_r + cnt_r[IW-1:0]) & MASK;
  assign probe_empty = !mem_rdata.valid;
  assign probe_hit   = mem_rdata.valid && (mem_rdata.key == cp_r);
  assign probe_last  = (cnt_r == CNT_LAST);
  assign scan_issue  = (cnt_r != CNT_END);
  assign scan_done   = (cnt_r == CNT_END) && !scan_vld_r;
  assign res_valid   = (state_r == ST_RESP);
  assign res_beat    = res_r;

  // The stamp counter skips zero on wrap; zero marks a never-touched slot.
  assign stamp_inc = stamp_r + 1'b1;
  assign stamp_new = (stamp_inc == '0) ? {{(STAMP_W-1){1'b0}}, 1'b1} : stamp_inc;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: begin
        if (probe_last) begin
          state_nxt = sweep_resp_r ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_beat.op)
            OP_LOOKUP: state_nxt = ST_PROBE_RD;
            OP_INSERT: state_nxt = ST_PROBE_RD;
            OP_CLEAR:  state_nxt = ST_SWEEP;
            default:   state_nxt = ST_RESP;
          endcase
        end
      end
      ST_PROBE_RD: state_nxt = ST_PROBE_CHK;
      ST_PROBE_CHK: begin
        if (probe_empty || probe_hit) begin
          state_nxt = ST_RESP;
        end else if (probe_last) begin
          state_nxt = (op_r == OP_INSERT) ? ST_SCAN : ST_RESP;
        end else begin
          state_nxt = ST_PROBE_RD;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_EVICT;
        end
      end
      ST_EVICT: state_nxt = ST_RESP;
      ST_RESP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory controls and result.
  always_comb begin
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    cp_nxt         = cp_r;
    gl_nxt         = gl_r;
    home_nxt       = home_r;
    stamp_nxt      = stamp_r;
    best_nxt       = best_r;
    tgt_nxt        = tgt_r;
    tgt_vld_nxt    = tgt_vld_r;
    scan_vld_nxt   = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    sweep_resp_nxt = sweep_resp_r;
    res_nxt        = res_r;
    mem_re         = 1'b0;
    mem_raddr      = probe_idx;
    mem_we         = 1'b0;
    mem_waddr      = rd_idx_r;
    mem_wdata      = mem_rdata;

    case (state_r)
      // Write a zero entry to every slot, one per cycle.
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[IW-1:0];
        mem_wdata = '0;
        cnt_nxt   = CW'(cnt_r + 1'b1);
        res_nxt   = '0;
      end

      // Capture the beat and its home slot.
      ST_IDLE: begin
        if (accept) begin
          op_nxt         = in_beat.op;
          cp_nxt         = in_beat.codepoint;
          gl_nxt         = in_beat.glyph_in;
          home_nxt       = home;
          cnt_nxt        = '0;
          sweep_resp_nxt = (in_beat.op == OP_CLEAR);
          res_nxt        = '0;
        end
      end

      ST_PROBE_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = probe_idx;
        rd_idx_nxt = probe_idx;
      end

      // Examine the probed slot and write back on a hit, or on an empty slot for an insert.
      ST_PROBE_CHK: begin
        if (probe_hit) begin
          mem_we          = 1'b1;
          mem_wdata.stamp = stamp_new;
          stamp_nxt       = stamp_new;
          res_nxt.found   = 1'b1;
          if (op_r == OP_INSERT) begin
            mem_wdata.glyph = gl_r;
          end else begin
            res_nxt.glyph_out = mem_rdata.glyph;
          end
        end else if (probe_empty) begin
          if (op_r == OP_INSERT) begin
            mem_we    = 1'b1;
            mem_wdata = '{valid: 1'b1, key: cp_r, glyph: gl_r, stamp: stamp_new};
            stamp_nxt = stamp_new;
          end
        end else begin
          cnt_nxt = probe_last ? '0 : CW'(cnt_r + 1'b1);
        end
      end

      // Stream every slot past a running minimum of the use stamps.
      ST_SCAN: begin
        if (scan_issue) begin
          mem_re       = 1'b1;
          mem_raddr    = cnt_r[IW-1:0];
          rd_idx_nxt   = cnt_r[IW-1:0];
          scan_vld_nxt = 1'b1;
          cnt_nxt      = CW'(cnt_r + 1'b1);
        end
        if (scan_vld_r) begin
          if ((rd_idx_r == '0) || (mem_rdata.stamp < best_r)) begin
            best_nxt    = mem_rdata.stamp;
            tgt_nxt     = rd_idx_r;
            tgt_vld_nxt = mem_rdata.valid;
          end
        end
      end

      // Replace the least recently stamped slot.
      ST_EVICT: begin
        mem_we          = 1'b1;
        mem_waddr       = tgt_r;
        mem_wdata       = '{valid: 1'b1, key: cp_r, glyph: gl_r, stamp: stamp_new};
        stamp_nxt       = stamp_new;
        res_nxt.evicted = tgt_vld_r;
      end

      ST_RESP: begin
        sweep_resp_nxt = 1'b0;
      end

      default: begin
        res_nxt = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      cnt_r        <= '0;
      stamp_r      <= '0;
      scan_vld_r   <= 1'b0;
      sweep_resp_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      stamp_r      <= stamp_nxt;
      scan_vld_r   <= scan_vld_nxt;
      sweep_resp_r <= sweep_resp_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    cp_r      <= cp_nxt;
    gl_r      <= gl_nxt;
    home_r    <= home_nxt;
    best_r    <= best_nxt;
    tgt_r     <= tgt_nxt;
    tgt_vld_r <= tgt_vld_nxt;
    rd_idx_r  <= rd_idx_nxt;
    res_r     <= res_nxt;
  end

  // The memory is never read and written in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_re && mem_we))
    else $error("entry memory read and written in the same cycle");

  // Once the stamp counter has left zero it never returns there.
  a_stamp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (stamp_r != '0) |=> (stamp_r != '0))
    else $error("stamp counter wrapped to zero");

  // The shared counter never runs past the table size.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_END)
    else $error("slot counter out of range");

  // The eviction target is always a real slot.
  a_tgt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVICT) |-> (tgt_r <= MASK))
    else $error("eviction target beyond the table");

  // A scan always hands over to the eviction write.
  a_scan_to_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && scan_done |=> (state_r == ST_EVICT))
    else $error("eviction scan did not end in an eviction");

endmodule

`default_nettype wire
